// ----- src/tlpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared constants and controller/datapath interface types of the leaf
// probability combiner.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  localparam int MAX_LEAVES     = 64;
  localparam int NUM_INTERNAL   = MAX_LEAVES - 1;
  localparam int PROB_FRAC_BITS = 15;
  localparam int PROB_W         = 16;
  localparam int CNT_W          = 7;
  localparam int ADDR_W         = 6;
  localparam int PAIR_W         = 2 * PROB_W;
  localparam int CHILD_W        = 2 * CNT_W;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1 << PROB_FRAC_BITS);
  localparam logic [PROB_W-1:0] PROB_SAT = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic build_start;
    logic build_step;
    logic load_wr;
    logic emit_start;
    logic walk_rd;
    logic walk_left;
    logic walk_right;
    logic out_rd;
    logic out_adv;
  } cmd_t;

  typedef struct packed {
    logic build_done;
    logic n_zero;
    logic n_one;
    logic walk_end;
    logic out_last;
  } sts_t;

endpackage

// ----- src/tlpc_ram.sv -----
// ----------------------------------------------------------------------------
// tlpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tlpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlpc_ctrl
// Sequencer: tree build, pair loads, top-down walk and leaf readout.
// ----------------------------------------------------------------------------
module tlpc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  input  logic            out_ready_i,
  input  tlpc_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output tlpc_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BSTART = 3'd1;
  localparam logic [2:0] ST_BUILD  = 3'd2;
  localparam logic [2:0] ST_WRD    = 3'd3;
  localparam logic [2:0] ST_WL     = 3'd4;
  localparam logic [2:0] ST_WR     = 3'd5;
  localparam logic [2:0] ST_ORD    = 3'd6;
  localparam logic [2:0] ST_OSEND  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       in_xfer;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OSEND);
  assign in_xfer     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op_i == tlpc_pkg::OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.emit_start = 1'b1;
            if (sts_i.n_one) begin
              state_d = ST_ORD;
            end else if (!sts_i.n_zero) begin
              state_d = ST_WRD;
            end
          end
        end
      end
      ST_BSTART: begin
        cmd_o.build_start = 1'b1;
        state_d = ST_BUILD;
      end
      ST_BUILD: begin
        if (sts_i.build_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.build_step = 1'b1;
        end
      end
      ST_WRD: begin
        cmd_o.walk_rd = 1'b1;
        state_d = ST_WL;
      end
      ST_WL: begin
        cmd_o.walk_left = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.walk_right = 1'b1;
        state_d = sts_i.walk_end ? ST_ORD : ST_WRD;
      end
      ST_ORD: begin
        cmd_o.out_rd = 1'b1;
        state_d = ST_OSEND;
      end
      ST_OSEND: begin
        if (out_ready_i) begin
          cmd_o.out_adv = 1'b1;
          state_d = sts_i.out_last ? ST_IDLE : ST_ORD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      state_d = ST_BSTART;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/tlpc_dp.sv -----
// ----------------------------------------------------------------------------
// tlpc_dp
// Datapath: leaf count, tree builder, pair/child/scale/leaf stores and the
// shared Q1.15 multiplier.
// ----------------------------------------------------------------------------
module tlpc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tlpc_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic [tlpc_pkg::PROB_W-1:0]       left_i,
  input  logic [tlpc_pkg::PROB_W-1:0]       right_i,
  input  tlpc_pkg::cmd_t                    cmd_i,
  output tlpc_pkg::sts_t                    sts_o,
  output logic [tlpc_pkg::ADDR_W-1:0]       leaf_index_o,
  output logic [tlpc_pkg::PROB_W-1:0]       leaf_prob_o
);

  localparam int CW = tlpc_pkg::CNT_W;
  localparam int AW = tlpc_pkg::ADDR_W;
  localparam int PW = tlpc_pkg::PROB_W;

  logic [CW-1:0] leaf_count_q;
  logic [CW-1:0] n_eff, n_m1, n_m2;
  logic [CW-1:0] load_cnt_q;
  logic          load_ok;

  logic [CW-1:0] base_q, m_q, carry_q, id_q;
  logic          cv_q;
  logic [AW-1:0] j_q;
  logic [CW-1:0] cnt, p0, p1, e0, e1, elast;
  logic [AW-1:0] half;
  logic          round_end;

  logic [AW-1:0] k_q, i_q;
  logic          root;

  logic [tlpc_pkg::PAIR_W-1:0]  pair_rdata;
  logic [tlpc_pkg::CHILD_W-1:0] child_rdata;
  logic [PW-1:0]                scale_rdata, leaf_rdata;

  logic [PW-1:0]   mul_a, mul_f, prod_sat;
  logic [2*PW-1:0] prod;
  logic [2*PW-1:0] prod_sh;
  logic [CW-1:0]   child;
  logic            child_leaf;
  logic            walk_wr;

  assign n_eff = (leaf_count_q > CW'(tlpc_pkg::MAX_LEAVES)) ?
                 CW'(tlpc_pkg::MAX_LEAVES) : leaf_count_q;
  assign n_m1  = n_eff - CW'(1);
  assign n_m2  = n_eff - CW'(2);
  assign load_ok = (n_eff != '0) && (load_cnt_q < n_m1);

  assign cnt   = m_q + CW'(cv_q);
  assign half  = cnt[CW-1:1];
  assign p0    = {j_q, 1'b0};
  assign p1    = {j_q, 1'b1};
  assign e0    = (p0 < m_q) ? base_q + p0 : carry_q;
  assign e1    = (p1 < m_q) ? base_q + p1 : carry_q;
  assign elast = ((cnt - CW'(1)) < m_q) ? base_q + cnt - CW'(1) : carry_q;
  assign round_end = (j_q == half);

  assign sts_o.build_done = (j_q == '0) && (cnt <= CW'(1));
  assign sts_o.n_zero     = (n_eff == '0);
  assign sts_o.n_one      = (n_eff == CW'(1));
  assign sts_o.walk_end   = (k_q == '0);
  assign sts_o.out_last   = ({1'b0, i_q} == n_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= '0;
      load_cnt_q   <= '0;
      base_q       <= '0;
      m_q          <= '0;
      cv_q         <= 1'b0;
      carry_q      <= '0;
      j_q          <= '0;
      id_q         <= '0;
      k_q          <= '0;
      i_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        leaf_count_q <= cfg_wdata_i;
      end
      if (cmd_i.build_start) begin
        base_q     <= '0;
        m_q        <= n_eff;
        cv_q       <= 1'b0;
        j_q        <= '0;
        id_q       <= n_eff;
        load_cnt_q <= '0;
      end
      if (cmd_i.build_step) begin
        if (round_end) begin
          cv_q    <= cnt[0];
          carry_q <= elast;
          base_q  <= id_q - CW'(half);
          m_q     <= CW'(half);
          j_q     <= '0;
        end else begin
          j_q  <= j_q + AW'(1);
          id_q <= id_q + CW'(1);
        end
      end
      if (cmd_i.load_wr && load_ok) begin
        load_cnt_q <= load_cnt_q + CW'(1);
      end
      if (cmd_i.emit_start) begin
        load_cnt_q <= '0;
        k_q        <= n_m2[AW-1:0];
        i_q        <= '0;
      end
      if (cmd_i.walk_right) begin
        k_q <= k_q - AW'(1);
      end
      if (cmd_i.out_adv) begin
        i_q <= i_q + AW'(1);
      end
    end
  end

  assign root     = (k_q == n_m2[AW-1:0]);
  assign mul_a    = cmd_i.walk_right ? pair_rdata[PW-1:0] : pair_rdata[2*PW-1:PW];
  assign mul_f    = root ? tlpc_pkg::PROB_ONE : scale_rdata;
  assign prod     = mul_a * mul_f;
  assign prod_sh  = prod >> tlpc_pkg::PROB_FRAC_BITS;
  assign prod_sat = (prod_sh[2*PW-1:PW] != '0) ? tlpc_pkg::PROB_SAT : prod_sh[PW-1:0];
  assign child    = cmd_i.walk_right ? child_rdata[CW-1:0] : child_rdata[2*CW-1:CW];
  assign child_leaf = (child < n_eff);
  assign walk_wr  = cmd_i.walk_left || cmd_i.walk_right;

  tlpc_ram #(.WIDTH(tlpc_pkg::PAIR_W), .DEPTH(tlpc_pkg::NUM_INTERNAL)) u_pair (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr && load_ok),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i ({left_i, right_i}),
    .re_i    (cmd_i.walk_rd),
    .raddr_i (k_q),
    .rdata_o (pair_rdata)
  );

  tlpc_ram #(.WIDTH(tlpc_pkg::CHILD_W), .DEPTH(tlpc_pkg::NUM_INTERNAL)) u_child (
    .clk_i   (clk_i),
    .we_i    (cmd_i.build_step && !round_end),
    .waddr_i (AW'(id_q - n_eff)),
    .wdata_i ({e0, e1}),
    .re_i    (cmd_i.walk_rd),
    .raddr_i (k_q),
    .rdata_o (child_rdata)
  );

  tlpc_ram #(.WIDTH(PW), .DEPTH(tlpc_pkg::NUM_INTERNAL)) u_scale (
    .clk_i   (clk_i),
    .we_i    (walk_wr && !child_leaf),
    .waddr_i (AW'(child - n_eff)),
    .wdata_i (prod_sat),
    .re_i    (cmd_i.walk_rd),
    .raddr_i (k_q),
    .rdata_o (scale_rdata)
  );

  tlpc_ram #(.WIDTH(PW), .DEPTH(tlpc_pkg::MAX_LEAVES)) u_leaf (
    .clk_i   (clk_i),
    .we_i    (walk_wr && child_leaf),
    .waddr_i (child[AW-1:0]),
    .wdata_i (prod_sat),
    .re_i    (cmd_i.out_rd),
    .raddr_i (i_q),
    .rdata_o (leaf_rdata)
  );

  assign leaf_index_o = i_q;
  assign leaf_prob_o  = sts_o.n_one ? tlpc_pkg::PROB_ONE : leaf_rdata;

endmodule

// ----- src/tree_leaf_probability_combiner.sv -----
// ----------------------------------------------------------------------------
// tree_leaf_probability_combiner
// Minimum-depth binary tree over N leaves; turns per-node branch pairs into
// per-leaf path probabilities (unsigned Q1.15).
//
// Usage:
//   cfg_we_i/cfg_wdata_i set the leaf count N (values above 64 act as 64).
//   A write rebuilds the child table with s_axis_tready low.
//   Slave channel: tuser = opcode, tdata = {right_prob, left_prob}.
//   A load transfer stores the next node pair; loads past N-1
//   are dropped. An emit transfer walks the N-1 internal nodes from the root,
//   each with one store read, then one multiply per child write on the single
//   store write port; then sends N results, each with a leaf store read, then
//   present, held while the receiver stalls.
//   An emit with N = 0 gives nothing; N = 1 gives one result of 1.0.
//   No transfer is accepted until the last result of an emit is taken; a
//   stalled result holds its data.
//   Reset: N = 0, load count cleared, empty tree, ready at once.
// ----------------------------------------------------------------------------
module tree_leaf_probability_combiner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] left_prob, [31:16] right_prob
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] leaf_index, [21:6] leaf_prob, [23:22] zero
  output logic        m_axis_tlast
);

  tlpc_pkg::cmd_t cmd;
  tlpc_pkg::sts_t sts;
  logic [tlpc_pkg::ADDR_W-1:0] leaf_index;
  logic [tlpc_pkg::PROB_W-1:0] leaf_prob;

  tlpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  tlpc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .left_i       (s_axis_tdata[15:0]),
    .right_i      (s_axis_tdata[31:16]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .leaf_index_o (leaf_index),
    .leaf_prob_o  (leaf_prob)
  );

  assign m_axis_tdata = {2'b00, leaf_prob, leaf_index};
  assign m_axis_tlast = sts.out_last;

endmodule

// ----- src/tlpc_checker.sv -----
// ----------------------------------------------------------------------------
// tlpc_checker
// Port-level checks of the leaf probability combiner.
// ----------------------------------------------------------------------------
module tlpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  a_mid_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input ready inside an emit");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
    else $error("padding bits set");

endmodule

bind tree_leaf_probability_combiner tlpc_checker u_tlpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
